@@ rtl/dhcp_tlv_pkg.sv @@
// ----------------------------------------------------------------------------
// dhcp_tlv_pkg
// Shared types, codes and the tag class table of the DHCP option parser.
// ----------------------------------------------------------------------------
package dhcp_tlv_pkg;

  localparam logic [1:0] PH_COOKIE = 2'd0;
  localparam logic [1:0] PH_TYPE   = 2'd1;
  localparam logic [1:0] PH_LEN    = 2'd2;
  localparam logic [1:0] PH_VALUE  = 2'd3;

  localparam logic [1:0] ROLE_COOKIE = 2'd0;
  localparam logic [1:0] ROLE_TYPE   = 2'd1;
  localparam logic [1:0] ROLE_LEN    = 2'd2;
  localparam logic [1:0] ROLE_VALUE  = 2'd3;

  localparam logic [1:0] CL_HEX = 2'd0;
  localparam logic [1:0] CL_IP  = 2'd1;
  localparam logic [1:0] CL_STR = 2'd2;
  localparam logic [1:0] CL_INT = 2'd3;

  localparam logic [2:0] COOKIE_LEN   = 3'd4;
  localparam logic [7:0] TAG_PAD      = 8'd0;
  localparam logic [7:0] TAG_END      = 8'd255;
  localparam logic [7:0] TAG_MSG_TYPE = 8'd53;
  localparam logic [7:0] POS_MAX      = 8'd255;

  typedef struct packed {
    logic [1:0]  phase;
    logic [2:0]  cookie_cnt;
    logic [7:0]  tag;
    logic [7:0]  owed;
    logic [7:0]  pos;
    logic [31:0] shift;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  byte_role;
    logic [7:0]  option_type;
    logic [7:0]  option_length;
    logic [7:0]  value_byte;
    logic [7:0]  value_index;
    logic [1:0]  value_class;
    logic        word_valid;
    logic [31:0] word;
    logic        message_type_valid;
    logic [7:0]  message_type;
    logic        option_done;
    logic        truncated;
  } parse_result_t;

  function automatic logic [1:0] class_of(input logic [7:0] tag);
    logic [1:0] cls;
    unique case (tag)
      8'd1, 8'd3, 8'd6, 8'd28, 8'd44, 8'd50, 8'd54: cls = CL_IP;
      8'd12, 8'd15, 8'd47:                           cls = CL_STR;
      8'd51, 8'd58, 8'd59:                           cls = CL_INT;
      default:                                       cls = CL_HEX;
    endcase
    return cls;
  endfunction

endpackage

@@ rtl/dhcp_option_tlv_parser.sv @@
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser
// Byte-wise parser of the DHCP/BOOTP vendor options area.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one vendor-area byte per word, cookie first; in_tlast marks the
//           last byte of the packet.
//   out_* : exactly one labelled word per input byte, in order.
//   out_tvalid rises once the byte has passed the input register and then the
//   result register. Throughput is one byte per cycle while out_tready stays
//   high: the parser state update is a combinational step done as a byte
//   moves from the input register to the result register.
//   After in_tlast the parser returns to the cookie phase for the next
//   packet. A byte after the end tag is parsed as another option.
//   Reset (rst_n low, synchronous) empties both registers and puts the
//   parser in the cookie phase.
//   When out_tready is low the result register holds and the input register
//   still takes one more byte; in_tready then drops until the result drains.
// ----------------------------------------------------------------------------
module dhcp_option_tlv_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] option_type, [15:8] option_length, [23:16] value_byte,
  // [31:24] value_index, [63:32] word, [71:64] message_type
  output logic [71:0] out_tdata,
  // [1:0] byte_role, [3:2] value_class, [4] word_valid,
  // [5] message_type_valid, [6] truncated
  output logic [6:0]  out_tuser,
  output logic        out_tlast   // option_done
);
  import dhcp_tlv_pkg::*;

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;
  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_result_t step_res;
  parse_result_t out_res_r;
  logic          out_valid_r;
  logic          out_free;
  logic          advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  dhcp_tlv_step u_step (
    .state         (state_r),
    .data_byte     (s1_byte_r),
    .end_of_packet (s1_last_r),
    .state_nxt     (state_nxt),
    .result        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.message_type, out_res_r.word, out_res_r.value_index,
                       out_res_r.value_byte, out_res_r.option_length,
                       out_res_r.option_type};
  assign out_tuser  = {out_res_r.truncated, out_res_r.message_type_valid,
                       out_res_r.word_valid, out_res_r.value_class, out_res_r.byte_role};
  assign out_tlast  = out_res_r.option_done;

  a_word_on_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.word_valid) |-> (out_res_r.byte_role == ROLE_VALUE))
    else $error("word_valid on a non-value byte");

  a_done_trunc_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.option_done && out_res_r.truncated))
    else $error("option_done and truncated together");

  a_eop_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |=> (state_r.phase == PH_COOKIE && state_r.cookie_cnt == 3'd0))
    else $error("parser not back in cookie phase after end of packet");

  a_msg_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.message_type_valid) |->
      (out_res_r.option_type == TAG_MSG_TYPE && out_res_r.value_index == 8'd0))
    else $error("message type reported outside option 53 first value byte");

endmodule

@@ rtl/dhcp_tlv_step.sv @@
// ----------------------------------------------------------------------------
// dhcp_tlv_step
// Per-byte parse step: labels one byte and computes the next parser state.
// ----------------------------------------------------------------------------
module dhcp_tlv_step (
  input  dhcp_tlv_pkg::parse_state_t  state,
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_packet,
  output dhcp_tlv_pkg::parse_state_t  state_nxt,
  output dhcp_tlv_pkg::parse_result_t result
);
  import dhcp_tlv_pkg::*;

  logic [31:0] shift_in;
  logic [7:0]  owed_dec;
  logic [1:0]  tag_cls;

  assign shift_in = {state.shift[23:0], data_byte};
  assign owed_dec = (state.owed != 8'd0) ? (state.owed - 8'd1) : state.owed;
  assign tag_cls  = class_of(state.tag);

  always_comb begin
    result    = '0;
    state_nxt = state;
    unique case (state.phase)
      PH_COOKIE: begin
        result.byte_role     = ROLE_COOKIE;
        state_nxt.cookie_cnt = state.cookie_cnt + 3'd1;
        if (state_nxt.cookie_cnt >= COOKIE_LEN) begin
          state_nxt.phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        result.byte_role   = ROLE_TYPE;
        result.option_type = data_byte;
        result.value_class = class_of(data_byte);
        state_nxt.tag      = data_byte;
        if (data_byte == TAG_PAD || data_byte == TAG_END) begin
          result.option_done = 1'b1;
        end else begin
          state_nxt.phase  = PH_LEN;
          result.truncated = end_of_packet;
        end
      end
      PH_LEN: begin
        result.byte_role     = ROLE_LEN;
        result.option_type   = state.tag;
        result.option_length = data_byte;
        result.value_class   = tag_cls;
        if (data_byte == 8'd0) begin
          result.option_done = 1'b1;
          state_nxt.phase    = PH_TYPE;
        end else begin
          state_nxt.owed   = data_byte;
          state_nxt.pos    = 8'd0;
          state_nxt.shift  = '0;
          state_nxt.phase  = PH_VALUE;
          result.truncated = end_of_packet;
        end
      end
      PH_VALUE: begin
        result.byte_role     = ROLE_VALUE;
        result.option_type   = state.tag;
        result.option_length = state.pos + state.owed;
        result.value_byte    = data_byte;
        result.value_index   = state.pos;
        result.value_class   = tag_cls;
        if (tag_cls == CL_IP) begin
          state_nxt.shift = shift_in;
          if (state.pos[1:0] == 2'b11) begin
            result.word_valid = 1'b1;
            result.word       = shift_in;
          end
        end else if (tag_cls == CL_INT) begin
          if (state.pos < 8'd4) begin
            state_nxt.shift = shift_in;
          end
          if (state.pos == 8'd3) begin
            result.word_valid = 1'b1;
            result.word       = shift_in;
          end
        end
        if (state.tag == TAG_MSG_TYPE && state.pos == 8'd0) begin
          result.message_type_valid = 1'b1;
          result.message_type       = data_byte;
        end
        if (state.pos != POS_MAX) begin
          state_nxt.pos = state.pos + 8'd1;
        end
        state_nxt.owed = owed_dec;
        if (owed_dec == 8'd0) begin
          result.option_done = 1'b1;
          state_nxt.phase    = PH_TYPE;
        end else begin
          result.truncated = end_of_packet;
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase
    if (end_of_packet) begin
      state_nxt = '0;
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dhcp_option_tlv_parser. Vendor-area packets
// (directed, then random with truncation and noise) stream in with bursty
// valid; every labelled output word is checked against a local parse model.
// ----------------------------------------------------------------------------
module tb;
  import dhcp_tlv_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [6:0]  out_tuser;
  logic        out_tlast;

  in_word_t      byte_stream_q[$];
  parse_result_t expected_labels[$];
  int            fail_count = 0;
  int            cycle_count = 0;
  int            items_queued = 0;
  bit            in_fire = 1'b0;
  int            burst_left = 0;
  int            gap_left = 0;
  bit            hold_req = 1'b0;
  int            hold_left = 0;

  // parse model state
  logic [1:0]  ph = PH_COOKIE;
  logic [2:0]  cookie_seen = '0;
  logic [7:0]  cur_tag = '0;
  logic [7:0]  owed = '0;
  logic [7:0]  vpos = '0;
  logic [31:0] vshift = '0;

  logic [7:0] ip_tags [7] = '{8'd1, 8'd3, 8'd6, 8'd28, 8'd44, 8'd50, 8'd54};
  logic [7:0] str_tags [3] = '{8'd12, 8'd15, 8'd47};
  logic [7:0] int_tags [3] = '{8'd51, 8'd58, 8'd59};

  dhcp_option_tlv_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [1:0] tag_value_class(input logic [7:0] tag);
    case (tag)
      8'd1, 8'd3, 8'd6, 8'd28, 8'd44, 8'd50, 8'd54: return CL_IP;
      8'd12, 8'd15, 8'd47:                           return CL_STR;
      8'd51, 8'd58, 8'd59:                           return CL_INT;
      default:                                       return CL_HEX;
    endcase
  endfunction

  function automatic void clear_parse_state();
    ph = PH_COOKIE;
    cookie_seen = '0;
    cur_tag = '0;
    owed = '0;
    vpos = '0;
    vshift = '0;
  endfunction

  function automatic parse_result_t label_byte(input logic [7:0] b, input logic eop);
    parse_result_t r;
    logic [7:0] pos;
    r = '0;
    case (ph)
      PH_COOKIE: begin
        r.byte_role = ROLE_COOKIE;
        cookie_seen = cookie_seen + 3'd1;
        if (cookie_seen >= COOKIE_LEN) ph = PH_TYPE;
      end
      PH_TYPE: begin
        r.byte_role = ROLE_TYPE;
        cur_tag = b;
        r.option_type = b;
        r.value_class = tag_value_class(b);
        if (b == TAG_PAD || b == TAG_END) begin
          r.option_done = 1'b1;
        end else begin
          ph = PH_LEN;
          r.truncated = eop;
        end
      end
      PH_LEN: begin
        r.byte_role = ROLE_LEN;
        r.option_type = cur_tag;
        r.option_length = b;
        r.value_class = tag_value_class(cur_tag);
        if (b == 8'd0) begin
          r.option_done = 1'b1;
          ph = PH_TYPE;
        end else begin
          owed = b;
          vpos = '0;
          vshift = '0;
          ph = PH_VALUE;
          r.truncated = eop;
        end
      end
      default: begin
        pos = vpos;
        r.byte_role = ROLE_VALUE;
        r.option_type = cur_tag;
        r.option_length = pos + owed;
        r.value_byte = b;
        r.value_index = pos;
        r.value_class = tag_value_class(cur_tag);
        if (r.value_class == CL_IP) begin
          vshift = {vshift[23:0], b};
          if (pos[1:0] == 2'd3) begin
            r.word_valid = 1'b1;
            r.word = vshift;
          end
        end else if (r.value_class == CL_INT) begin
          if (pos < 8'd4) vshift = {vshift[23:0], b};
          if (pos == 8'd3) begin
            r.word_valid = 1'b1;
            r.word = vshift;
          end
        end
        if (cur_tag == TAG_MSG_TYPE && pos == 8'd0) begin
          r.message_type_valid = 1'b1;
          r.message_type = b;
        end
        if (pos < POS_MAX) vpos = pos + 8'd1;
        if (owed > 8'd0) owed = owed - 8'd1;
        if (owed == 8'd0) begin
          r.option_done = 1'b1;
          ph = PH_TYPE;
        end else if (eop) begin
          r.truncated = 1'b1;
        end
      end
    endcase
    if (eop) clear_parse_state();
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      fail_count++;
    end
  endtask

  task automatic check_label(input parse_result_t want, input parse_result_t got);
    check_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
    check_field("option_type", 32'(want.option_type), 32'(got.option_type));
    check_field("option_length", 32'(want.option_length), 32'(got.option_length));
    check_field("value_byte", 32'(want.value_byte), 32'(got.value_byte));
    check_field("value_index", 32'(want.value_index), 32'(got.value_index));
    check_field("value_class", 32'(want.value_class), 32'(got.value_class));
    check_field("word_valid", 32'(want.word_valid), 32'(got.word_valid));
    check_field("word", want.word, got.word);
    check_field("message_type_valid", 32'(want.message_type_valid),
                32'(got.message_type_valid));
    check_field("message_type", 32'(want.message_type), 32'(got.message_type));
    check_field("option_done", 32'(want.option_done), 32'(got.option_done));
    check_field("truncated", 32'(want.truncated), 32'(got.truncated));
  endtask

  // input accept and output check, both sampled at the rising edge
  always @(posedge clk) begin
    parse_result_t got;
    in_fire = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '0;
        got.option_type        = out_tdata[7:0];
        got.option_length      = out_tdata[15:8];
        got.value_byte         = out_tdata[23:16];
        got.value_index        = out_tdata[31:24];
        got.word               = out_tdata[63:32];
        got.message_type       = out_tdata[71:64];
        got.byte_role          = out_tuser[1:0];
        got.value_class        = out_tuser[3:2];
        got.word_valid         = out_tuser[4];
        got.message_type_valid = out_tuser[5];
        got.truncated          = out_tuser[6];
        got.option_done        = out_tlast;
        if (expected_labels.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0h/%0h", $time,
                   out_tdata, out_tuser);
          fail_count++;
        end else begin
          check_label(expected_labels.pop_front(), got);
        end
      end
      if (in_tvalid && in_tready) begin
        in_fire = 1'b1;
        expected_labels.push_back(label_byte(in_tdata, in_tlast));
        void'(byte_stream_q.pop_front());
      end
    end
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;
    end else begin
      if (burst_left == 0 && gap_left == 0) begin
        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        burst_left = $urandom_range(1, 24);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (byte_stream_q.size() > 0) begin
        burst_left--;
        in_tvalid <= 1'b1;
        in_tdata <= byte_stream_q[0].data;
        in_tlast <= byte_stream_q[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches with bits [7:6] of the cycle count, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      case (cycle_count[7:6])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= cycle_count[0];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic queue_packet(input byte_q_t pkt);
    foreach (pkt[i]) begin
      byte_stream_q.push_back('{data: pkt[i], last: (i == pkt.size() - 1)});
      items_queued++;
    end
  endtask

  function automatic logic [7:0] pick_tag();
    case ($urandom_range(0, 15))
      0:       return TAG_PAD;
      1:       return TAG_END;
      2, 3, 4: return ip_tags[$urandom_range(0, 6)];
      5:       return str_tags[$urandom_range(0, 2)];
      6, 7:    return int_tags[$urandom_range(0, 2)];
      8:       return TAG_MSG_TYPE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_packet(input bit with_long);
    byte_q_t pkt;
    logic [7:0] tag;
    int len;
    int last_start;
    int n_opts;
    if ($urandom_range(0, 3) == 0) begin
      repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
    end else begin
      pkt = '{8'h63, 8'h82, 8'h53, 8'h63};
    end
    // packet ending inside the cookie
    if (!with_long && $urandom_range(0, 11) == 0) begin
      pkt = pkt[0:$urandom_range(0, 3)];
      queue_packet(pkt);
      return;
    end
    n_opts = $urandom_range(1, 6);
    last_start = 4;
    for (int k = 0; k < n_opts; k++) begin
      last_start = pkt.size();
      tag = (with_long && k == 0) ? 8'd200 : pick_tag();
      pkt.push_back(tag);
      if (tag == TAG_PAD || tag == TAG_END) continue;
      case (tag_value_class(tag))
        CL_IP:  len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11)
                                                  : 4 * $urandom_range(1, 3);
        CL_INT: len = $urandom_range(0, 8);
        default: begin
          if (tag == TAG_MSG_TYPE) len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 1;
          else len = $urandom_range(0, 12);
        end
      endcase
      if (with_long && k == 0) len = 255;
      pkt.push_back(8'(len));
      repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
    end
    // cut inside the last option
    if ($urandom_range(0, 3) == 0) pkt = pkt[0:$urandom_range(last_start, pkt.size() - 1)];
    queue_packet(pkt);
  endtask

  task automatic wait_for_drain();
    while (byte_stream_q.size() != 0 || expected_labels.size() != 0) @(posedge clk);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pad, message type, IP list with a leftover byte, long integer with an all-ones first word,
    // end tag followed by a zero-length string option
    queue_packet('{8'h63, 8'h82, 8'h53, 8'h63, 8'h00, 8'h35, 8'h01, 8'h05,
                   8'h01, 8'h05, 8'hc0, 8'ha8, 8'h01, 8'h01, 8'hff,
                   8'h33, 8'h06, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h01,
                   8'hff, 8'h0c, 8'h00});
    // ends inside the cookie
    queue_packet('{8'h63, 8'h82});
    // integer cut short
    queue_packet('{8'h63, 8'h82, 8'h53, 8'h63, 8'h3a, 8'h04, 8'h00, 8'h00});
    wait_for_drain();

    // receiver holds off while a long option keeps the sender busy
    hold_req = 1'b1;
    random_packet(1'b1);
    while (hold_req || hold_left != 0) @(posedge clk);

    while (items_queued < RANDOM_ITEMS) begin
      random_packet(1'b0);
      if (!paused && items_queued > RANDOM_ITEMS / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dhcp_tlv_pkg.sv
rtl/dhcp_tlv_step.sv
rtl/dhcp_option_tlv_parser.sv
dv/tb.sv
